// ----- rtl/swap_run_allocator_macros.svh -----
// Assertion macros shared by the allocator modules.
// Both macros expect a signal named clk in the scope where they are used; SRA_ASSERT also expects rst.
`ifndef SWAP_RUN_ALLOCATOR_MACROS_SVH
`define SWAP_RUN_ALLOCATOR_MACROS_SVH

`ifndef SYNTH

`define SRA_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("swap_run_allocator assertion failed");

`define SRA_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("swap_run_allocator assertion failed");

`else

`define SRA_ASSERT(label, prop)

`define SRA_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ----- rtl/sra_pkg.sv -----
`default_nettype none

package sra_pkg;

  localparam int MAX_SECTORS = 8192;
  localparam int RUN_LENGTH  = 8;
  localparam int WORD_W      = 64;
  localparam int NUM_WORDS   = MAX_SECTORS / WORD_W;
  localparam int SECT_W      = $clog2(MAX_SECTORS);
  localparam int WADDR_W     = $clog2(NUM_WORDS);
  localparam int OFF_W       = $clog2(WORD_W);
  localparam int SIZE_W      = SECT_W + 1;
  localparam int TAIL_W      = RUN_LENGTH - 1;
  localparam int CFG_W       = 14;
  localparam int START_W     = 13;
  localparam int CMP_W       = (CFG_W > SIZE_W) ? CFG_W : SIZE_W;

  localparam logic [CFG_W-1:0] USABLE_RESET = 14'd8192;

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic               has_slot;
    logic [START_W-1:0] slot_start;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [START_W-1:0] run_start;
  } rsp_t;

  typedef struct packed {
    logic accept;
    logic scan_step;
    logic take_hit;
    logic mod_rd;
    logic mod_wr;
    logic second;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic in_alloc;
    logic in_slot;
    logic hit;
    logic scan_done;
    logic span2;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/swap_run_allocator.sv -----
// An allocation scans the 64-bit bitmap words, one per cycle and at most 128 of them; when it finds
// a run it reads and writes the word that holds it, and the next word too when the run crosses a word.
// A release reads and writes the word or words of its run, and a release without a slot writes none;
// one transaction is in flight.
// A new request is taken while the previous response still waits in the output register.
// Synchronous reset marks every sector free at once through per-word valid bits; no clearing pass.
`default_nettype none

module swap_run_allocator import sra_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req_data,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  sra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sra_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule

`default_nettype wire

// ----- rtl/sra_datapath.sv -----
`default_nettype none

`include "swap_run_allocator_macros.svh"

module sra_datapath import sra_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  req_t             req_data,
  input  logic             cfg_valid,
  input  logic [CFG_W-1:0] cfg_data,
  input  cmd_t             cmd,
  output sts_t             sts,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp_data
);

  logic [CFG_W-1:0]      usable;
  logic [CMP_W-1:0]      usable_ext;
  logic [SIZE_W-1:0]     eff_size;

  logic [WORD_W-1:0]     mem [NUM_WORDS];
  logic [NUM_WORDS-1:0]  row_valid;

  logic [WORD_W-1:0]     rd_data;
  logic                  rd_row_ok;
  logic [WADDR_W-1:0]    rd_word;
  logic                  rd_live;
  logic [WADDR_W-1:0]    scan_ptr;
  logic [TAIL_W-1:0]     prev_tail;

  logic [SECT_W-1:0]     op_start;
  logic                  op_set;
  logic                  res_ok;
  logic [START_W-1:0]    res_start;

  logic [WADDR_W-1:0]    op_word_a;
  logic [OFF_W-1:0]      op_off;
  logic [WADDR_W-1:0]    op_word;
  logic [WADDR_W-1:0]    rd_addr;
  logic                  rd_en;
  logic [2*WORD_W-1:0]   run_mask2;
  logic [WORD_W-1:0]     mask_sel;
  logic [WORD_W-1:0]     cur;
  logic [WORD_W-1:0]     wr_data;

  logic [SIZE_W-1:0]     base;
  logic [SIZE_W-1:0]     room;
  logic [SIZE_W-1:0]     word_end;
  logic [WORD_W-1:0]     in_mask;
  logic [WORD_W-1:0]     free_bits;
  logic [WORD_W+TAIL_W-1:0] ext;
  logic [WORD_W-1:0]     ends;
  logic [OFF_W-1:0]      hit_idx;
  logic [SECT_W-1:0]     hit_start;

  assign usable_ext = CMP_W'(usable);
  assign eff_size   = (usable_ext > CMP_W'(MAX_SECTORS)) ? SIZE_W'(MAX_SECTORS)
                                                         : SIZE_W'(usable_ext);

  assign op_word_a = op_start[SECT_W-1:OFF_W];
  assign op_off    = op_start[OFF_W-1:0];
  assign op_word   = cmd.second ? op_word_a + WADDR_W'(1) : op_word_a;
  assign rd_addr   = cmd.scan_step ? scan_ptr : op_word;
  assign rd_en     = cmd.scan_step | cmd.mod_rd;

  assign run_mask2 = {{(2*WORD_W-RUN_LENGTH){1'b0}}, {RUN_LENGTH{1'b1}}} << op_off;
  assign mask_sel  = cmd.second ? run_mask2[2*WORD_W-1:WORD_W] : run_mask2[WORD_W-1:0];
  assign cur       = rd_row_ok ? rd_data : '0;
  assign wr_data   = op_set ? (cur | mask_sel) : (cur & ~mask_sel);

  assign base     = SIZE_W'({rd_word, {OFF_W{1'b0}}});
  assign room     = eff_size - base;
  assign word_end = base + SIZE_W'(WORD_W);

  always_comb begin
    if (base >= eff_size) begin
      in_mask = '0;
    end else if (room >= SIZE_W'(WORD_W)) begin
      in_mask = '1;
    end else begin
      in_mask = ~({WORD_W{1'b1}} << room[OFF_W-1:0]);
    end
  end

  assign free_bits = ~cur & in_mask;
  assign ext       = {free_bits, prev_tail};

  always_comb begin
    ends    = '0;
    hit_idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      ends[i] = &ext[i +: RUN_LENGTH];
    end
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (ends[i]) begin
        hit_idx = OFF_W'(i);
      end
    end
  end

  assign hit_start = {rd_word, hit_idx} - SECT_W'(TAIL_W);

  assign sts.in_alloc  = (req_data.req_type == REQ_ALLOC);
  assign sts.in_slot   = req_data.has_slot;
  assign sts.hit       = rd_live & (|ends);
  assign sts.scan_done = rd_live & ((word_end >= eff_size) ||
                                    (rd_word == WADDR_W'(NUM_WORDS - 1)));
  assign sts.span2     = (run_mask2[2*WORD_W-1:WORD_W] != '0) &&
                         (op_word_a != WADDR_W'(NUM_WORDS - 1));
  assign sts.out_free  = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      usable <= USABLE_RESET;
    end else if (cfg_valid) begin
      usable <= cfg_data;
    end
  end

  // A row that was never written since reset reads as all free.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.mod_wr) begin
      row_valid[op_word] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mod_wr) begin
      mem[op_word] <= wr_data;
    end
    if (rd_en) begin
      rd_data   <= mem[rd_addr];
      rd_row_ok <= row_valid[rd_addr];
      rd_word   <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_live <= 1'b0;
    end else begin
      rd_live <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      scan_ptr  <= '0;
      prev_tail <= '0;
    end else begin
      if (cmd.scan_step) begin
        scan_ptr <= scan_ptr + WADDR_W'(1);
      end
      if (rd_live) begin
        prev_tail <= free_bits[WORD_W-1 -: TAIL_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_start  <= SECT_W'(req_data.slot_start);
      op_set    <= (req_data.req_type == REQ_ALLOC);
      res_ok    <= (req_data.req_type == REQ_RELEASE) && req_data.has_slot;
      res_start <= '0;
    end else if (cmd.take_hit) begin
      op_start  <= hit_start;
      res_ok    <= 1'b1;
      res_start <= START_W'(hit_start);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_data.ok        <= res_ok;
      rsp_data.run_start <= res_start;
    end
  end

  `SRA_ASSERT(a_run_in_range, sts.hit |-> (SIZE_W'(hit_start) + SIZE_W'(RUN_LENGTH) <= eff_size))
  `SRA_ASSERT(a_wr_after_rd, cmd.mod_wr |-> $past(cmd.mod_rd))
  `SRA_ASSERT_ALWAYS(a_reset_empty, rst |=> (!rsp_valid && !rd_live))

endmodule

`default_nettype wire

// ----- rtl/sra_ctrl.sv -----
`default_nettype none

`include "swap_run_allocator_macros.svh"

module sra_ctrl import sra_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN    = 3'd1;
  localparam logic [2:0] ST_MOD_RD  = 3'd2;
  localparam logic [2:0] ST_MOD_WR  = 3'd3;
  localparam logic [2:0] ST_MOD_RD2 = 3'd4;
  localparam logic [2:0] ST_MOD_WR2 = 3'd5;
  localparam logic [2:0] ST_FINISH  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          if (sts.in_alloc) begin
            state_next = ST_SCAN;
          end else if (sts.in_slot) begin
            state_next = ST_MOD_RD;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (sts.hit) begin
          cmd.take_hit = 1'b1;
          state_next   = ST_MOD_RD;
        end else if (sts.scan_done) begin
          state_next = ST_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_MOD_RD: begin
        cmd.mod_rd = 1'b1;
        state_next = ST_MOD_WR;
      end
      ST_MOD_WR: begin
        cmd.mod_wr = 1'b1;
        state_next = sts.span2 ? ST_MOD_RD2 : ST_FINISH;
      end
      ST_MOD_RD2: begin
        cmd.mod_rd = 1'b1;
        cmd.second = 1'b1;
        state_next = ST_MOD_WR2;
      end
      ST_MOD_WR2: begin
        cmd.mod_wr = 1'b1;
        cmd.second = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `SRA_ASSERT(a_load_when_free, cmd.load_out |-> sts.out_free)
  `SRA_ASSERT(a_hit_only_in_scan, sts.hit |-> (state == ST_SCAN))
  `SRA_ASSERT(a_second_follows_first, (state == ST_MOD_RD2) |-> ($past(state) == ST_MOD_WR))

endmodule

`default_nettype wire
